@@ hw/rtl/bounding_sphere_merge_defines.svh @@
// ----------------------------------------------------------------------------
// Sphere merge assertion macros
// Shared property forms for the checkers of the sphere merge block.
// ----------------------------------------------------------------------------
`ifndef BOUNDING_SPHERE_MERGE_DEFINES_SVH
`define BOUNDING_SPHERE_MERGE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSM_ASSERT_NOW(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSM_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ hw/rtl/bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sphere merge package
// Types and constants shared by the sphere merge pipeline modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

   localparam int AXES = 3;

   // Per-word flags that ride along with the valid bit.
   typedef struct packed {
      logic contained;
      logic second;
   } bsm_tag_type;

endpackage

`default_nettype wire

@@ hw/rtl/bsm_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, restoring digit recurrence, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_sqrt #(
   parameter int RAD_W  = 66,
   parameter int SIDE_W = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  bsm_pkg::bsm_tag_type in_tag,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output bsm_pkg::bsm_tag_type out_tag,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]    out_side
);
   import bsm_pkg::*;

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic              valid_ff [ROOT_W];
   bsm_tag_type       tag_ff   [ROOT_W];
   logic [RAD_W-1:0]  rad_ff   [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];

   logic              valid_p  [ROOT_W];
   bsm_tag_type       tag_p    [ROOT_W];
   logic [RAD_W-1:0]  rad_p    [ROOT_W];
   logic [REM_W-1:0]  rem_p    [ROOT_W];
   logic [ROOT_W-1:0] root_p   [ROOT_W];
   logic [SIDE_W-1:0] side_p   [ROOT_W];

   logic [REM_W+1:0]  rem_sh   [ROOT_W];
   logic [REM_W+1:0]  trial    [ROOT_W];
   logic [REM_W-1:0]  rem_in   [ROOT_W];
   logic [ROOT_W-1:0] root_in  [ROOT_W];

   always_comb begin
      for (int k = 0; k < ROOT_W; k++) begin
         if (k == 0) begin
            valid_p[k] = in_valid;
            tag_p[k]   = in_tag;
            rad_p[k]   = in_rad;
            rem_p[k]   = '0;
            root_p[k]  = '0;
            side_p[k]  = in_side;
         end else begin
            valid_p[k] = valid_ff[k-1];
            tag_p[k]   = tag_ff[k-1];
            rad_p[k]   = rad_ff[k-1];
            rem_p[k]   = rem_ff[k-1];
            root_p[k]  = root_ff[k-1];
            side_p[k]  = side_ff[k-1];
         end
         // Bring down the next two radicand bits and try root*4+1.
         rem_sh[k] = {rem_p[k], rad_p[k][RAD_W-1 -: 2]};
         trial[k]  = {{(REM_W-ROOT_W){1'b0}}, root_p[k], 2'b01};
         if (rem_sh[k] >= trial[k]) begin
            rem_in[k]  = REM_W'(rem_sh[k] - trial[k]);
            root_in[k] = {root_p[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh[k][REM_W-1:0];
            root_in[k] = {root_p[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROOT_W; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_p[k];
         end
         if (adv) begin
            tag_ff[k]  <= tag_p[k];
            rad_ff[k]  <= rad_p[k] << 2;
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            side_ff[k] <= side_p[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/bsm_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined three-lane divider
// Restoring division, one quotient bit per stage, shared divisor per word.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_div #(
   parameter int DVS_W  = 33,
   parameter int SIDE_W = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    adv,
   input  logic                                    in_valid,
   input  bsm_pkg::bsm_tag_type                    in_tag,
   input  logic [bsm_pkg::AXES-1:0][2*DVS_W-1:0]   in_dvd,
   input  logic [DVS_W-1:0]                        in_dvs,
   input  logic [SIDE_W-1:0]                       in_side,
   output logic                                    out_valid,
   output bsm_pkg::bsm_tag_type                    out_tag,
   output logic [bsm_pkg::AXES-1:0][DVS_W-1:0]     out_quo,
   output logic [SIDE_W-1:0]                       out_side
);
   import bsm_pkg::*;

   localparam int STAGES = DVS_W;

   logic                        valid_ff [STAGES];
   bsm_tag_type                 tag_ff   [STAGES];
   logic [DVS_W-1:0]            dvs_ff   [STAGES];
   logic [AXES-1:0][DVS_W-1:0]  rem_ff   [STAGES];
   logic [AXES-1:0][DVS_W-1:0]  low_ff   [STAGES];
   logic [AXES-1:0][DVS_W-1:0]  quo_ff   [STAGES];
   logic [SIDE_W-1:0]           side_ff  [STAGES];

   logic                        valid_p  [STAGES];
   bsm_tag_type                 tag_p    [STAGES];
   logic [DVS_W-1:0]            dvs_p    [STAGES];
   logic [AXES-1:0][DVS_W-1:0]  rem_p    [STAGES];
   logic [AXES-1:0][DVS_W-1:0]  low_p    [STAGES];
   logic [AXES-1:0][DVS_W-1:0]  quo_p    [STAGES];
   logic [SIDE_W-1:0]           side_p   [STAGES];

   logic [AXES-1:0][DVS_W:0]    rsh      [STAGES];
   logic [AXES-1:0][DVS_W-1:0]  rem_in   [STAGES];
   logic [AXES-1:0][DVS_W-1:0]  quo_in   [STAGES];

   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            valid_p[k] = in_valid;
            tag_p[k]   = in_tag;
            dvs_p[k]   = in_dvs;
            side_p[k]  = in_side;
            quo_p[k]   = '0;
            // The quotient fits DVS_W bits, so the upper half is below the divisor.
            for (int l = 0; l < AXES; l++) begin
               rem_p[k][l] = in_dvd[l][2*DVS_W-1:DVS_W];
               low_p[k][l] = in_dvd[l][DVS_W-1:0];
            end
         end else begin
            valid_p[k] = valid_ff[k-1];
            tag_p[k]   = tag_ff[k-1];
            dvs_p[k]   = dvs_ff[k-1];
            side_p[k]  = side_ff[k-1];
            quo_p[k]   = quo_ff[k-1];
            rem_p[k]   = rem_ff[k-1];
            low_p[k]   = low_ff[k-1];
         end
         for (int l = 0; l < AXES; l++) begin
            rsh[k][l] = {rem_p[k][l], low_p[k][l][DVS_W-1]};
            if (rsh[k][l] >= {1'b0, dvs_p[k]}) begin
               rem_in[k][l] = DVS_W'(rsh[k][l] - {1'b0, dvs_p[k]});
               quo_in[k][l] = {quo_p[k][l][DVS_W-2:0], 1'b1};
            end else begin
               rem_in[k][l] = rsh[k][l][DVS_W-1:0];
               quo_in[k][l] = {quo_p[k][l][DVS_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_p[k];
         end
         if (adv) begin
            tag_ff[k]  <= tag_p[k];
            dvs_ff[k]  <= dvs_p[k];
            side_ff[k] <= side_p[k];
            rem_ff[k]  <= rem_in[k];
            quo_ff[k]  <= quo_in[k];
            for (int l = 0; l < AXES; l++) begin
               low_ff[k][l] <= low_p[k][l] << 1;
            end
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];
   assign out_quo   = quo_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

`default_nettype wire

@@ hw/rtl/bounding_sphere_merge.sv @@
// ----------------------------------------------------------------------------
// Enclosing sphere of two spheres
// Pipelined merge of two Q16.16 spheres into the smallest enclosing sphere.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one word per sphere pair: two centers and two
//   radii. The rsp_ channel returns one word per request, in order: the
//   enclosing center and radius, and a flag that is set when one sphere
//   already held the other.
//   The pipeline has four input stages, one stage per root bit in the square
//   root pipeline, two stages for the radius and the offset products, one
//   stage per quotient bit in the divider, and the output register.
//   Throughput is one word per cycle while the response is not stalled; both
//   long units are fully pipelined.
//   A stalled response freezes the whole pipeline and holds req_stall high
//   for as long as rsp_stall holds the response; nothing is dropped.
//   Synchronous reset empties every stage; no word is shown after reset
//   until a new request has gone through.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_sphere_merge #(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_first_center_x,
   input  logic signed [COORD_BITS-1:0] req_first_center_y,
   input  logic signed [COORD_BITS-1:0] req_first_center_z,
   input  logic        [COORD_BITS-2:0] req_first_radius,
   input  logic signed [COORD_BITS-1:0] req_second_center_x,
   input  logic signed [COORD_BITS-1:0] req_second_center_y,
   input  logic signed [COORD_BITS-1:0] req_second_center_z,
   input  logic        [COORD_BITS-2:0] req_second_radius,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_merged_center_x,
   output logic signed [COORD_BITS-1:0] rsp_merged_center_y,
   output logic signed [COORD_BITS-1:0] rsp_merged_center_z,
   output logic        [COORD_BITS-2:0] rsp_merged_radius,
   output logic                         rsp_contained_case
);
   import bsm_pkg::*;

   localparam int N  = COORD_BITS;
   localparam int SQ = 2 * N + 2;

   typedef struct packed {
      logic [AXES-1:0][N-1:0] c0;
      logic [AXES-1:0][N-1:0] c1;
      logic [AXES-1:0][N:0]   mag;
      logic [AXES-1:0]        neg;
      logic [N-2:0]           r0;
      logic [N-2:0]           r1;
   } geo_type;

   typedef struct packed {
      logic [AXES-1:0][N-1:0] c0;
      logic [AXES-1:0][N-1:0] c1;
      logic [AXES-1:0]        neg;
      logic [N-2:0]           r0;
      logic [N-2:0]           r1;
      logic [N:0]             rad;
      logic                   dzero;
   } fin_type;

   function automatic logic [N-1:0] sat_coord(input logic signed [N+1:0] v);
      logic signed [N+1:0] hi;
      logic signed [N+1:0] lo;
      hi = $signed({3'b000, {(N-1){1'b1}}});
      lo = $signed({3'b111, {(N-1){1'b0}}});
      if (v > hi) begin
         sat_coord = hi[N-1:0];
      end else if (v < lo) begin
         sat_coord = lo[N-1:0];
      end else begin
         sat_coord = v[N-1:0];
      end
   endfunction

   logic adv;

   // Stage 1: differences, magnitudes and radius difference.
   logic [AXES-1:0][N-1:0] c0_in;
   logic [AXES-1:0][N-1:0] c1_in;
   geo_type                s1_geo_in;
   logic [N-2:0]           s1_rdm_in;
   bsm_tag_type            s1_tag_in;

   logic                   s1_valid_ff;
   geo_type                s1_geo_ff;
   logic [N-2:0]           s1_rdm_ff;
   bsm_tag_type            s1_tag_ff;

   // Stage 2: squares.
   logic                   s2_valid_ff;
   geo_type                s2_geo_ff;
   logic [AXES-1:0][SQ-1:0] s2_sq_ff;
   logic [2*N-3:0]         s2_rdm2_ff;
   bsm_tag_type            s2_tag_ff;

   // Stage 3: squared distance.
   logic                   s3_valid_ff;
   geo_type                s3_geo_ff;
   logic [SQ-1:0]          s3_d2_ff;
   logic [2*N-3:0]         s3_rdm2_ff;
   bsm_tag_type            s3_tag_ff;

   // Stage 4: containment test.
   logic                   s4_valid_ff;
   geo_type                s4_geo_ff;
   logic [SQ-1:0]          s4_d2_ff;
   bsm_tag_type            s4_tag_ff;
   bsm_tag_type            s4_tag_in;

   // Square root output.
   logic                   q_valid;
   bsm_tag_type            q_tag;
   logic [N:0]             q_root;
   logic [$bits(geo_type)-1:0] q_side;
   geo_type                q_geo;

   // Stage 5: radius and step length.
   logic [N+1:0]           s5_sum;
   logic [N:0]             s5_rad_in;
   logic [N:0]             s5_t_in;
   logic                   s5_valid_ff;
   geo_type                s5_geo_ff;
   bsm_tag_type            s5_tag_ff;
   logic [N:0]             s5_d_ff;
   logic [N:0]             s5_rad_ff;

   // Stage 6: offset numerators.
   logic                   s6_valid_ff;
   bsm_tag_type            s6_tag_ff;
   logic [AXES-1:0][SQ-1:0] s6_prod_ff;
   logic [N:0]             s6_d_ff;
   fin_type                s6_fin_ff;
   fin_type                s6_fin_in;

   // Divider output.
   logic                   v_valid;
   bsm_tag_type            v_tag;
   logic [AXES-1:0][N:0]   v_quo;
   logic [$bits(fin_type)-1:0] v_side;
   fin_type                v_fin;

   // Output register.
   logic [AXES-1:0][N-1:0] out_c_in;
   logic [N-2:0]           out_r_in;
   logic                   rsp_valid_ff;
   logic [AXES-1:0][N-1:0] rsp_c_ff;
   logic [N-2:0]           rsp_r_ff;
   logic                   rsp_cont_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   assign c0_in[0] = req_first_center_x;
   assign c0_in[1] = req_first_center_y;
   assign c0_in[2] = req_first_center_z;
   assign c1_in[0] = req_second_center_x;
   assign c1_in[1] = req_second_center_y;
   assign c1_in[2] = req_second_center_z;

   always_comb begin
      s1_geo_in.c0 = c0_in;
      s1_geo_in.c1 = c1_in;
      s1_geo_in.r0 = req_first_radius;
      s1_geo_in.r1 = req_second_radius;
      for (int i = 0; i < AXES; i++) begin
         s1_geo_in.neg[i] = $signed(c1_in[i]) < $signed(c0_in[i]);
         if (s1_geo_in.neg[i]) begin
            s1_geo_in.mag[i] = (N+1)'({c0_in[i][N-1], c0_in[i]} - {c1_in[i][N-1], c1_in[i]});
         end else begin
            s1_geo_in.mag[i] = (N+1)'({c1_in[i][N-1], c1_in[i]} - {c0_in[i][N-1], c0_in[i]});
         end
      end
      s1_tag_in.second    = req_second_radius >= req_first_radius;
      s1_tag_in.contained = 1'b0;
      if (s1_tag_in.second) begin
         s1_rdm_in = req_second_radius - req_first_radius;
      end else begin
         s1_rdm_in = req_first_radius - req_second_radius;
      end
   end

   always_comb begin
      s4_tag_in           = s3_tag_ff;
      s4_tag_in.contained = s3_d2_ff <= {4'b0000, s3_rdm2_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
      if (adv) begin
         s1_geo_ff  <= s1_geo_in;
         s1_rdm_ff  <= s1_rdm_in;
         s1_tag_ff  <= s1_tag_in;

         s2_geo_ff  <= s1_geo_ff;
         s2_tag_ff  <= s1_tag_ff;
         s2_rdm2_ff <= s1_rdm_ff * s1_rdm_ff;
         for (int i = 0; i < AXES; i++) begin
            s2_sq_ff[i] <= s1_geo_ff.mag[i] * s1_geo_ff.mag[i];
         end

         s3_geo_ff  <= s2_geo_ff;
         s3_tag_ff  <= s2_tag_ff;
         s3_rdm2_ff <= s2_rdm2_ff;
         s3_d2_ff   <= s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];

         s4_geo_ff  <= s3_geo_ff;
         s4_tag_ff  <= s4_tag_in;
         s4_d2_ff   <= s3_d2_ff;
      end
   end

   bsm_sqrt #(
      .RAD_W  (SQ),
      .SIDE_W ($bits(geo_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s4_valid_ff),
      .in_tag    (s4_tag_ff),
      .in_rad    (s4_d2_ff),
      .in_side   (s4_geo_ff),
      .out_valid (q_valid),
      .out_tag   (q_tag),
      .out_root  (q_root),
      .out_side  (q_side)
   );

   assign q_geo = geo_type'(q_side);

   always_comb begin
      s5_sum    = {3'b000, q_geo.r0} + {3'b000, q_geo.r1} + {1'b0, q_root};
      s5_rad_in = s5_sum[N+1:1];
   end

   // The step toward the second center never exceeds d outside containment.
   assign s5_t_in = (s5_rad_ff >= {2'b00, s5_geo_ff.r0}) ?
                    (N+1)'(s5_rad_ff - {2'b00, s5_geo_ff.r0}) : '0;

   always_comb begin
      s6_fin_in.c0    = s5_geo_ff.c0;
      s6_fin_in.c1    = s5_geo_ff.c1;
      s6_fin_in.neg   = s5_geo_ff.neg;
      s6_fin_in.r0    = s5_geo_ff.r0;
      s6_fin_in.r1    = s5_geo_ff.r1;
      s6_fin_in.rad   = s5_rad_ff;
      s6_fin_in.dzero = s5_d_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= q_valid;
         s6_valid_ff <= s5_valid_ff;
      end
      if (adv) begin
         s5_geo_ff <= q_geo;
         s5_tag_ff <= q_tag;
         s5_d_ff   <= q_root;
         s5_rad_ff <= s5_rad_in;

         s6_tag_ff <= s5_tag_ff;
         s6_d_ff   <= s5_d_ff;
         s6_fin_ff <= s6_fin_in;
         for (int i = 0; i < AXES; i++) begin
            s6_prod_ff[i] <= s5_geo_ff.mag[i] * s5_t_in;
         end
      end
   end

   bsm_div #(
      .DVS_W  (N + 1),
      .SIDE_W ($bits(fin_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s6_valid_ff),
      .in_tag    (s6_tag_ff),
      .in_dvd    (s6_prod_ff),
      .in_dvs    (s6_d_ff),
      .in_side   (s6_fin_ff),
      .out_valid (v_valid),
      .out_tag   (v_tag),
      .out_quo   (v_quo),
      .out_side  (v_side)
   );

   assign v_fin = fin_type'(v_side);

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         if (v_tag.contained) begin
            out_c_in[i] = v_tag.second ? v_fin.c1[i] : v_fin.c0[i];
         end else if (v_fin.dzero) begin
            out_c_in[i] = v_fin.c0[i];
         end else if (v_fin.neg[i]) begin
            out_c_in[i] = sat_coord($signed({{2{v_fin.c0[i][N-1]}}, v_fin.c0[i]})
                                    - $signed({1'b0, v_quo[i]}));
         end else begin
            out_c_in[i] = sat_coord($signed({{2{v_fin.c0[i][N-1]}}, v_fin.c0[i]})
                                    + $signed({1'b0, v_quo[i]}));
         end
      end
      if (v_tag.contained) begin
         out_r_in = v_tag.second ? v_fin.r1 : v_fin.r0;
      end else if (v_fin.rad > {2'b00, {(N-1){1'b1}}}) begin
         out_r_in = {(N-1){1'b1}};
      end else begin
         out_r_in = v_fin.rad[N-2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_valid;
      end
      if (adv) begin
         rsp_c_ff    <= out_c_in;
         rsp_r_ff    <= out_r_in;
         rsp_cont_ff <= v_tag.contained;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_merged_center_x = rsp_c_ff[0];
   assign rsp_merged_center_y = rsp_c_ff[1];
   assign rsp_merged_center_z = rsp_c_ff[2];
   assign rsp_merged_radius   = rsp_r_ff;
   assign rsp_contained_case  = rsp_cont_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bsm_checker.sv @@
// ----------------------------------------------------------------------------
// Sphere merge port checker
// Watches the top level ports for flow control and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounding_sphere_merge_defines.svh"

module bsm_checker #(
   parameter int COORD_BITS = 32
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [COORD_BITS-2:0] rsp_merged_radius,
   input wire logic                  rsp_contained_case
);

   `BSM_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid, "response word dropped while stalled")
   `BSM_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_merged_radius) && $stable(rsp_contained_case), "response word changed while stalled")
   `BSM_ASSERT_NOW(a_stall_cause, 1'b1, req_stall == (rsp_valid && rsp_stall), "request stall does not follow the blocked response")
   `BSM_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid, "response shown right after reset")

endmodule

bind bounding_sphere_merge bsm_checker #(.COORD_BITS(COORD_BITS)) u_bsm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_merged_radius  (rsp_merged_radius),
   .rsp_contained_case (rsp_contained_case)
);

`default_nettype wire

@@ tb/sv/bounding_sphere_merge_test.sv @@
// ----------------------------------------------------------------------------
// Sphere merge testbench
// Drives sphere pairs through the merge block under random idling and stalls,
// predicts each enclosing sphere with exact wide arithmetic and compares the
// responses in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounding_sphere_merge_test;

   localparam int CB = 32;
   localparam int LATENCY = 2 * CB + 9;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_WORDS = 2000;

   typedef struct {
      logic signed [CB-1:0] c0x, c0y, c0z;
      logic [CB-2:0] r0;
      logic signed [CB-1:0] c1x, c1y, c1z;
      logic [CB-2:0] r1;
   } pair_word_type;

   typedef struct {
      logic signed [CB-1:0] cx, cy, cz;
      logic [CB-2:0] rad;
      logic contained;
   } sphere_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CB-1:0] req_first_center_x = '0, req_first_center_y = '0;
   logic signed [CB-1:0] req_first_center_z = '0;
   logic [CB-2:0] req_first_radius = '0;
   logic signed [CB-1:0] req_second_center_x = '0, req_second_center_y = '0;
   logic signed [CB-1:0] req_second_center_z = '0;
   logic [CB-2:0] req_second_radius = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic signed [CB-1:0] rsp_merged_center_x, rsp_merged_center_y, rsp_merged_center_z;
   logic [CB-2:0] rsp_merged_radius;
   logic rsp_contained_case;

   pair_word_type pending_pairs[$];
   sphere_word_type expected_spheres[$];
   bit stimulus_done = 0;
   bit calm_phase = 0;
   bit hold_off_done = 0;
   int error_count = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int stall_burst = 0;
   int hold_off_count = 0;

   bounding_sphere_merge #(.COORD_BITS(CB)) u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] isqrt(input logic [127:0] v);
      logic [63:0] res;
      logic [63:0] cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         if ({64'd0, cand} * {64'd0, cand} <= v) res = cand;
      end
      return res;
   endfunction

   function automatic logic signed [CB-1:0] clamp_coord(input logic signed [127:0] v);
      if (v > 128'sd2147483647) return 32'sh7fffffff;
      if (v < -128'sd2147483648) return 32'sh80000000;
      return v[CB-1:0];
   endfunction

   function automatic sphere_word_type enclose_pair(input pair_word_type p);
      sphere_word_type s;
      logic signed [127:0] c0[3], dv[3], off;
      logic signed [CB-1:0] c1[3];
      logic [127:0] d2, rdm, mag, d, rad, t;
      c0[0] = p.c0x; c0[1] = p.c0y; c0[2] = p.c0z;
      c1[0] = p.c1x; c1[1] = p.c1y; c1[2] = p.c1z;
      d2 = '0;
      for (int i = 0; i < 3; i++) begin
         dv[i] = 128'(c1[i]) - c0[i];
         mag = dv[i] < 0 ? -dv[i] : dv[i];
         d2 += mag * mag;
      end
      rdm = p.r1 >= p.r0 ? p.r1 - p.r0 : p.r0 - p.r1;
      if (d2 <= rdm * rdm) begin
         s.contained = 1'b1;
         if (p.r1 >= p.r0) begin
            s.cx = p.c1x; s.cy = p.c1y; s.cz = p.c1z; s.rad = p.r1;
         end else begin
            s.cx = p.c0x; s.cy = p.c0y; s.cz = p.c0z; s.rad = p.r0;
         end
         return s;
      end
      s.contained = 1'b0;
      d = isqrt(d2);
      rad = (128'(p.r0) + p.r1 + d) >> 1;
      t = rad >= p.r0 ? rad - p.r0 : 0;
      for (int i = 0; i < 3; i++) begin
         mag = dv[i] < 0 ? -dv[i] : dv[i];
         off = d > 0 ? (mag * t) / d : 0;
         c0[i] = dv[i] < 0 ? c0[i] - off : c0[i] + off;
      end
      s.cx = clamp_coord(c0[0]);
      s.cy = clamp_coord(c0[1]);
      s.cz = clamp_coord(c0[2]);
      s.rad = rad > 128'h7fffffff ? 31'h7fffffff : rad[CB-2:0];
      return s;
   endfunction

   function automatic logic signed [CB-1:0] random_coord(input int span);
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 2 * span)) - span;
         2: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, span)
                                        : 32'sh80000000 + $urandom_range(0, span);
         default: return $signed($urandom_range(0, 2 * span)) - span;
      endcase
   endfunction

   function automatic logic [CB-2:0] random_radius(input int span);
      case ($urandom_range(0, 3))
         0: return (CB-1)'($urandom);
         1: return (CB-1)'(31'h7fffffff - $urandom_range(0, span));
         default: return (CB-1)'($urandom_range(0, span));
      endcase
   endfunction

   task automatic push_pair(input logic signed [CB-1:0] ax, ay, az, input logic [CB-2:0] ar,
                            input logic signed [CB-1:0] bx, by, bz, input logic [CB-2:0] br);
      pair_word_type p;
      p.c0x = ax; p.c0y = ay; p.c0z = az; p.r0 = ar;
      p.c1x = bx; p.c1y = by; p.c1z = bz; p.r1 = br;
      pending_pairs.push_back(p);
   endtask

   initial begin
      pair_word_type p;
      int span;
      // Directed words: extremes, containment both ways and the tie, coincident centers.
      push_pair(0, 0, 0, 0, 0, 0, 0, 0);
      push_pair(0, 0, 0, 100, 0, 0, 0, 100);
      push_pair(10, 20, 30, 5, 10, 20, 30, 7);
      push_pair(10, 20, 30, 9, 10, 20, 30, 7);
      push_pair(0, 0, 0, 65536 * 10, 65536, 0, 0, 65536);
      push_pair(0, 0, 0, 65536, 65536, 0, 0, 65536 * 10);
      push_pair(0, 0, 0, 65536, 65536 * 4, 0, 0, 65536);
      push_pair(32'sh80000000, 32'sh80000000, 32'sh80000000, 0,
                32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
      push_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff,
                32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff);
      push_pair(32'sh80000000, 0, 32'sh7fffffff, 31'h7fffffff,
                32'sh7fffffff, 0, 32'sh80000000, 0);
      push_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0,
                32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff);
      push_pair(-1, -1, -1, 1, 1, 1, 1, 1);
      push_pair(0, 0, 0, 0, 1, 0, 0, 0);
      push_pair(0, 0, 0, 0, 0, -1, 0, 0);
      push_pair(5, 5, 5, 3, 5, 5, 8, 0);
      push_pair(-7, 3, 0, 31'h7fffffff, 7, -3, 0, 31'h7fffffff);
      push_pair(32'shffffffff, 32'shaaaaaaaa, 32'sh55555555, 31'h55555555,
                32'sh55555555, 32'sh55555555, 32'shaaaaaaaa, 31'h2aaaaaaa);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         span = n % 10 == 0 ? 32'h3fffffff : 1 << $urandom_range(1, 24);
         p.c0x = random_coord(span); p.c0y = random_coord(span);
         p.c0z = random_coord(span); p.r0 = random_radius(span);
         if ($urandom_range(0, 2) == 0) begin
            // Second sphere close to the first, so containment shows up often.
            p.c1x = p.c0x + $signed($urandom_range(0, 64)) - 32;
            p.c1y = p.c0y + $signed($urandom_range(0, 64)) - 32;
            p.c1z = p.c0z + $signed($urandom_range(0, 64)) - 32;
            p.r1 = (CB-1)'(p.r0 + $urandom_range(0, 200) - 100);
         end else begin
            p.c1x = random_coord(span); p.c1y = random_coord(span);
            p.c1z = random_coord(span); p.r1 = random_radius(span);
         end
         pending_pairs.push_back(p);
      end
   end

   // Sender: offers words from the queue with random bursts of idling.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_spheres.push_back(enclose_pair(pending_pairs.pop_front()));
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!calm_phase && req_valid && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else if ((req_valid ? pending_pairs.size() > 0 : pending_pairs.size() > 0)) begin
            req_valid <= 1'b1;
            req_first_center_x <= pending_pairs[0].c0x;
            req_first_center_y <= pending_pairs[0].c0y;
            req_first_center_z <= pending_pairs[0].c0z;
            req_first_radius <= pending_pairs[0].r0;
            req_second_center_x <= pending_pairs[0].c1x;
            req_second_center_y <= pending_pairs[0].c1y;
            req_second_center_z <= pending_pairs[0].c1z;
            req_second_radius <= pending_pairs[0].r1;
         end else begin
            req_valid <= 1'b0;
            stimulus_done <= 1'b1;
         end
         if (pending_pairs.size() < 300) calm_phase <= 1'b1;
      end
   end

   // Receiver: random stall bursts, one long hold-off to back the pipeline up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (!hold_off_done && expected_spheres.size() > 20) begin
         rsp_stall <= 1'b1;
         hold_off_count <= hold_off_count + 1;
         if (hold_off_count >= 400) hold_off_done <= 1'b1;
      end else if (stall_burst > 0) begin
         stall_burst <= stall_burst - 1;
         rsp_stall <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
         stall_burst <= $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Checker of the response words against the predicted spheres.
   always @(posedge clock) begin
      sphere_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_spheres.size() == 0) begin
            $error("response word with nothing expected");
            error_count++;
         end else begin
            e = expected_spheres.pop_front();
            if (rsp_merged_center_x !== e.cx) begin
               $error("merged_center_x expected %0d actual %0d", e.cx, rsp_merged_center_x);
               error_count++;
            end
            if (rsp_merged_center_y !== e.cy) begin
               $error("merged_center_y expected %0d actual %0d", e.cy, rsp_merged_center_y);
               error_count++;
            end
            if (rsp_merged_center_z !== e.cz) begin
               $error("merged_center_z expected %0d actual %0d", e.cz, rsp_merged_center_z);
               error_count++;
            end
            if (rsp_merged_radius !== e.rad) begin
               $error("merged_radius expected %0d actual %0d", e.rad, rsp_merged_radius);
               error_count++;
            end
            if (rsp_contained_case !== e.contained) begin
               $error("contained_case expected %0d actual %0d", e.contained,
                      rsp_contained_case);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && expected_spheres.size() == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && expected_spheres.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_sqrt.sv
hw/rtl/bsm_div.sv
hw/rtl/bounding_sphere_merge.sv
hw/rtl/bsm_checker.sv
tb/sv/bounding_sphere_merge_test.sv
